// ----- rtl/arming_safety_interlock_fsm_unit_defines.svh -----
// Assertion macros for the arming safety interlock unit.
// Used by modules that check their own logic; expects clk_i and rst_ni in scope.
`ifndef ARMING_SAFETY_INTERLOCK_FSM_UNIT_DEFINES_SVH
`define ARMING_SAFETY_INTERLOCK_FSM_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define ASI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/asi_pkg.sv -----
// Shared types and constants for the arming safety interlock unit.
// No dependencies.
`default_nettype none

package asi_pkg;

  localparam int unsigned TIMER_BITS_DEF = 20;
  localparam int unsigned REG_W          = 20;
  localparam int unsigned STATE_W        = 3;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [REG_W-1:0] REG_MAX              = '1;
  localparam logic [REG_W-1:0] BOOT_WAIT_MS_RST     = 20'd1000;
  localparam logic [REG_W-1:0] CALIB_LIMIT_MS_RST   = 20'd30000;
  localparam logic [REG_W-1:0] SENSOR_STALE_MS_RST  = 20'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOOT_WAIT    = 2'd0,
    REG_CALIB_LIMIT  = 2'd1,
    REG_SENSOR_STALE = 2'd2
  } asi_reg_e;

  typedef struct packed {
    logic arm_switch;
    logic serial_arm;
    logic enable_req;
    logic calib_done;
    logic sensor_ok_flag;
    logic sensor_update;
    logic force_fault;
  } asi_tick_t;

  typedef struct packed {
    logic [REG_W-1:0] boot_wait_ms;
    logic [REG_W-1:0] calib_limit_ms;
    logic [REG_W-1:0] sensor_stale_ms;
  } asi_cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0] state_now;
    logic [STATE_W-1:0] state_before;
    logic [REG_W-1:0]   ms_in_state;
    logic               sensors_good;
    logic               changed;
  } asi_res_t;

endpackage

`default_nettype wire

// ----- rtl/asi_if.sv -----
// Channel interfaces of the arming safety interlock unit: tick, result, config write.
// Depends on asi_pkg for field widths.
`default_nettype none

interface asi_tick_if;
  logic valid;
  logic ready;
  logic arm_switch;
  logic serial_arm;
  logic enable_req;
  logic calib_done;
  logic sensor_ok_flag;
  logic sensor_update;
  logic force_fault;

  modport source (
    output valid, arm_switch, serial_arm, enable_req, calib_done,
           sensor_ok_flag, sensor_update, force_fault,
    input  ready
  );
  modport sink (
    input  valid, arm_switch, serial_arm, enable_req, calib_done,
           sensor_ok_flag, sensor_update, force_fault,
    output ready
  );
endinterface

interface asi_res_if;
  logic                       valid;
  logic                       ready;
  logic [asi_pkg::STATE_W-1:0] state_now;
  logic [asi_pkg::STATE_W-1:0] state_before;
  logic [asi_pkg::REG_W-1:0]   ms_in_state;
  logic                       sensors_good;
  logic                       changed;

  modport source (
    output valid, state_now, state_before, ms_in_state, sensors_good, changed,
    input  ready
  );
  modport sink (
    input  valid, state_now, state_before, ms_in_state, sensors_good, changed,
    output ready
  );
endinterface

interface asi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [asi_pkg::CFG_IDX_W-1:0] index;
  logic [asi_pkg::REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/arming_safety_interlock_fsm_unit.sv -----
// Top level of the arming safety interlock unit: handshakes, config registers, result register.
// Depends on asi_pkg, asi_if.sv and asi_fsm.
`default_nettype none

//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------
//  tick_i   | in  | valid / ready | arm, serial arm, enable, calib, sensor flags
//  res_o    | out | valid / ready | state now/before, ms in state, good, changed
//  cfg_i    | in  | valid / ready | register index, 20-bit write data
//
//  One tick request is taken every cycle while the result register has room; its result is held in the result
//  register from the next cycle on. The state update and result are one level
//  of compare/increment logic between the state registers and that register.
//  Reset puts the machine in boot with cleared timers and config at defaults.
//  A stalled result blocks a new tick only while it is still not taken;
//  taking it and accepting the next tick happen in the same cycle.
//  Config writes are always ready and are registered.

module arming_safety_interlock_fsm_unit import asi_pkg::*; #(
  parameter int unsigned TimerBits = TIMER_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  asi_tick_if.sink   tick_i,
  asi_res_if.source  res_o,
  asi_cfg_if.sink    cfg_i
);

  asi_cfg_t  cfg_q;
  asi_tick_t tick;
  asi_res_t  res_d, res_q;
  logic      vld_q;
  logic      acc;

  // ---- config registers ----
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boot_wait_ms    <= BOOT_WAIT_MS_RST;
      cfg_q.calib_limit_ms  <= CALIB_LIMIT_MS_RST;
      cfg_q.sensor_stale_ms <= SENSOR_STALE_MS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BOOT_WAIT:    cfg_q.boot_wait_ms    <= cfg_i.data;
        REG_CALIB_LIMIT:  cfg_q.calib_limit_ms  <= cfg_i.data;
        REG_SENSOR_STALE: cfg_q.sensor_stale_ms <= cfg_i.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---- tick request side ----
  // Room in the result register if it is empty or being drained now.
  assign tick_i.ready = !vld_q || res_o.ready;
  assign acc          = tick_i.valid && tick_i.ready;

  always_comb begin
    tick.arm_switch     = tick_i.arm_switch;
    tick.serial_arm     = tick_i.serial_arm;
    tick.enable_req     = tick_i.enable_req;
    tick.calib_done     = tick_i.calib_done;
    tick.sensor_ok_flag = tick_i.sensor_ok_flag;
    tick.sensor_update  = tick_i.sensor_update;
    tick.force_fault    = tick_i.force_fault;
  end

  asi_fsm #(
    .TimerBits (TimerBits)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (acc),
    .tick_i (tick),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (acc) begin
      vld_q <= 1'b1;
    end else if (res_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = vld_q;
  assign res_o.state_now    = res_q.state_now;
  assign res_o.state_before = res_q.state_before;
  assign res_o.ms_in_state  = res_q.ms_in_state;
  assign res_o.sensors_good = res_q.sensors_good;
  assign res_o.changed      = res_q.changed;

endmodule

`default_nettype wire

// ----- rtl/asi_fsm.sv -----
// Interlock state machine: state, previous state, entry timer and sensor age.
// Depends on asi_pkg and the assertion macro header.
`default_nettype none
`include "arming_safety_interlock_fsm_unit_defines.svh"

module asi_fsm import asi_pkg::*; #(
  parameter int unsigned TimerBits = TIMER_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  asi_tick_t tick_i,
  input  asi_cfg_t  cfg_i,
  output asi_res_t  res_o
);

  localparam int unsigned CmpW = (TimerBits > REG_W) ? TimerBits : REG_W;

  typedef enum logic [STATE_W-1:0] {
    ST_BOOT   = 3'd0,
    ST_CALIB  = 3'd1,
    ST_IDLE   = 3'd2,
    ST_ARMED  = 3'd3,
    ST_ACTIVE = 3'd4,
    ST_FAULT  = 3'd5
  } state_e;

  state_e               st_q, st_d, prev_q, prev_d, nxt;
  logic [TimerBits-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [TimerBits-1:0] age_q, age_d;
  logic [CmpW-1:0]      elapsed_x, age_x, ms_x;
  logic                 good, chg, arm_ok;

  always_comb begin
    elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
    if (tick_i.sensor_update) begin
      age_d = '0;
    end else begin
      age_d = (&age_q) ? age_q : age_q + 1'b1;
    end
    elapsed_x = CmpW'(elapsed_inc);
    age_x     = CmpW'(age_d);
    good      = tick_i.sensor_ok_flag && (age_x < CmpW'(cfg_i.sensor_stale_ms));
    arm_ok    = tick_i.arm_switch && tick_i.serial_arm;

    nxt = st_q;
    case (st_q)
      ST_BOOT: begin
        if (elapsed_x > CmpW'(cfg_i.boot_wait_ms)) nxt = ST_CALIB;
      end
      ST_CALIB: begin
        if (tick_i.calib_done) nxt = ST_IDLE;
        else if (elapsed_x > CmpW'(cfg_i.calib_limit_ms)) nxt = ST_FAULT;
      end
      ST_IDLE: begin
        if (arm_ok && good) nxt = ST_ARMED;
        else if (!good) nxt = ST_FAULT;
      end
      ST_ARMED: begin
        if (!arm_ok) nxt = ST_IDLE;
        else if (tick_i.enable_req && good) nxt = ST_ACTIVE;
        else if (!good) nxt = ST_FAULT;
      end
      ST_ACTIVE: begin
        if (!arm_ok || !tick_i.enable_req) nxt = ST_ARMED;
        else if (!good) nxt = ST_FAULT;
      end
      default: nxt = st_q;
    endcase

    // forced fault wins, and re-enters fault even when already there
    if (tick_i.force_fault) begin
      nxt = ST_FAULT;
    end
    chg = tick_i.force_fault || (nxt != st_q);

    st_d      = nxt;
    prev_d    = chg ? st_q : prev_q;
    elapsed_d = chg ? '0 : elapsed_inc;

    ms_x               = CmpW'(elapsed_d);
    res_o.state_now    = st_d;
    res_o.state_before = prev_d;
    res_o.ms_in_state  = (ms_x > CmpW'(REG_MAX)) ? REG_MAX : ms_x[REG_W-1:0];
    res_o.sensors_good = good;
    res_o.changed      = chg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_BOOT;
      prev_q    <= ST_BOOT;
      elapsed_q <= '0;
      age_q     <= '0;
    end else if (adv_i) begin
      st_q      <= st_d;
      prev_q    <= prev_d;
      elapsed_q <= elapsed_d;
      age_q     <= age_d;
    end
  end

  `ASI_ASSERT(a_fault_sticky, (st_q == ST_FAULT) |=> (st_q == ST_FAULT), "fault state left")
  `ASI_ASSERT(a_force_fault, (adv_i && tick_i.force_fault) |=> (st_q == ST_FAULT) && (elapsed_q == '0), "forced fault not taken")
  `ASI_ASSERT(a_restart, (adv_i && res_o.changed) |=> (elapsed_q == '0) && (prev_q == $past(st_q)), "transition bookkeeping wrong")
  `ASI_ASSERT_RST(a_reset_boot, !rst_ni |-> (st_q == ST_BOOT) && (age_q == '0), "reset state wrong")

endmodule

`default_nettype wire
